### rtl/core/hse_pkg.sv
// shared types, constants and fixed-point helpers of the hermite series evaluator
`default_nettype none
package hse_pkg;

    localparam int DATA_W        = 32;
    localparam int PROD_W        = 2 * DATA_W;
    localparam int MAX_TERMS     = 6;
    localparam int CFG_ADDR_W    = 3;
    localparam int FRAC_BITS_MIN = 8;
    localparam int FRAC_BITS_DEF = 16;
    localparam int NUM_TERMS_DEF = 6;
    // coef_0 plus up to five rescaled 32x32 products, with sign and headroom
    localparam int ACC_W         = PROD_W - FRAC_BITS_MIN + 4;

    localparam logic signed [PROD_W-1:0] SAT_HI = (PROD_W'(1) <<< (DATA_W - 1)) - PROD_W'(1);
    localparam logic signed [PROD_W-1:0] SAT_LO = -(PROD_W'(1) <<< (DATA_W - 1));

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_COEF_0,
        REG_COEF_1,
        REG_COEF_2,
        REG_COEF_3,
        REG_COEF_4,
        REG_COEF_5,
        REG_MEAN_OFFSET,
        REG_INV_SCALE
    } cfg_reg_t;

    // item state handed from cell to cell
    typedef struct packed {
        logic signed [DATA_W-1:0] z;
        logic signed [DATA_W-1:0] h_prev;
        logic signed [DATA_W-1:0] h_curr;
        logic signed [ACC_W-1:0]  acc;
        logic                     ovf;
    } hse_bus_t;

    // multiply-back by 2^-frac, halves round toward +inf
    function automatic logic signed [PROD_W-1:0] rescale(
        input logic signed [PROD_W-1:0] p,
        input int                       frac
    );
        logic signed [PROD_W-1:0] half;
        half = PROD_W'(1) <<< (frac - 1);
        return (p + half) >>> frac;
    endfunction

    function automatic logic is_sat(input logic signed [PROD_W-1:0] v);
        return (v > SAT_HI) || (v < SAT_LO);
    endfunction

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] r;
        if (v > SAT_HI)
        begin
            r = SAT_HI;
        end
        else if (v < SAT_LO)
        begin
            r = SAT_LO;
        end
        else
        begin
            r = v;
        end
        return r[DATA_W-1:0];
    endfunction

endpackage
`default_nettype wire

### rtl/core/hermite_series_evaluator_top.sv
// top level of the hermite series evaluator: registers, cell chain and output stage
//
// usage: samples x (signed fixed point, FRAC_BITS fraction bits) enter on the
// s_ stream, one item per cycle at most; each gives one result item on the m_
// stream holding sum coef_n * He_n((x - mean_offset) * inv_scale), saturated,
// and an overflow flag set when any intermediate or the sum saturated.
// pipeline: the front cell, then the recurrence cells (He_2 upward, NUM_TERMS - 2
// cells), then the output register.
// throughput: one item per cycle; each stage register carries its own valid bit,
// so the chain keeps accepting while empty stages remain, even when a result
// waits at the output. a stalled receiver fills the chain, then s_tready drops.
// configuration: cfg_we writes cfg_data to register cfg_addr (coef_0..coef_5,
// mean_offset, inv_scale); write only while no item is in flight.
// reset clears the chain, sets coefficients and mean_offset to zero and
// inv_scale to 1.0; no clearing pass is needed.
`default_nettype none
module hermite_series_evaluator_top #(
    parameter int NUM_TERMS = hse_pkg::NUM_TERMS_DEF,
    parameter int FRAC_BITS = hse_pkg::FRAC_BITS_DEF
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire [hse_pkg::DATA_W-1:0]        s_tdata,   // [31:0] sample
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic [hse_pkg::DATA_W-1:0]       m_tdata,   // [31:0] series_value
    output logic                             m_tuser,   // [0] overflow
    input  wire                              cfg_we,
    input  wire [hse_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire [hse_pkg::DATA_W-1:0]        cfg_data
);

    localparam int DW   = hse_pkg::DATA_W;
    localparam int LAST = (NUM_TERMS > 2) ? NUM_TERMS - 2 : 0;
    localparam logic [DW-1:0] INV_ONE = DW'(1) << FRAC_BITS;

    logic signed [DW-1:0] coef_reg [hse_pkg::MAX_TERMS];
    logic signed [DW-1:0] mean_reg;
    logic        [DW-1:0] inv_scale_reg;

    logic              link_valid [0:LAST];
    logic              link_ready [0:LAST];
    hse_pkg::hse_bus_t link_bus   [0:LAST];

    logic                 m_tvalid_reg;
    logic [DW-1:0]        series_reg;
    logic                 ovf_reg;
    logic                 out_rdy;
    logic signed [hse_pkg::PROD_W-1:0] acc_wide;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < hse_pkg::MAX_TERMS; i++)
            begin
                coef_reg[i] <= '0;
            end
            mean_reg      <= '0;
            inv_scale_reg <= INV_ONE;
        end
        else if (cfg_we)
        begin
            unique case (hse_pkg::cfg_reg_t'(cfg_addr))
                hse_pkg::REG_COEF_0:      coef_reg[0]   <= cfg_data;
                hse_pkg::REG_COEF_1:      coef_reg[1]   <= cfg_data;
                hse_pkg::REG_COEF_2:      coef_reg[2]   <= cfg_data;
                hse_pkg::REG_COEF_3:      coef_reg[3]   <= cfg_data;
                hse_pkg::REG_COEF_4:      coef_reg[4]   <= cfg_data;
                hse_pkg::REG_COEF_5:      coef_reg[5]   <= cfg_data;
                hse_pkg::REG_MEAN_OFFSET: mean_reg      <= cfg_data;
                hse_pkg::REG_INV_SCALE:   inv_scale_reg <= cfg_data;
            endcase
        end
    end

    hse_front #(
        .NUM_TERMS (NUM_TERMS),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .sample      (s_tdata),
        .coef_0      (coef_reg[0]),
        .coef_1      (coef_reg[1]),
        .mean_offset (mean_reg),
        .inv_scale   (inv_scale_reg),
        .out_valid   (link_valid[0]),
        .out_ready   (link_ready[0]),
        .out_bus     (link_bus[0])
    );

    for (genvar n = 2; n < NUM_TERMS; n++)
    begin : g_cell
        hse_cell #(
            .ORDER     (n),
            .FRAC_BITS (FRAC_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (link_valid[n-2]),
            .in_ready  (link_ready[n-2]),
            .in_bus    (link_bus[n-2]),
            .coef      (coef_reg[n]),
            .out_valid (link_valid[n-1]),
            .out_ready (link_ready[n-1]),
            .out_bus   (link_bus[n-1])
        );
    end

    assign out_rdy          = !m_tvalid_reg || m_tready;
    assign link_ready[LAST] = out_rdy;
    assign acc_wide         = hse_pkg::PROD_W'(link_bus[LAST].acc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (out_rdy)
        begin
            m_tvalid_reg <= link_valid[LAST];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_rdy)
        begin
            series_reg <= hse_pkg::sat32(acc_wide);
            ovf_reg    <= link_bus[LAST].ovf || hse_pkg::is_sat(acc_wide);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = series_reg;
    assign m_tuser  = ovf_reg;

endmodule
`default_nettype wire

### rtl/core/hse_front.sv
// front cell: standardizes the sample and forms the He_0 and He_1 terms
`default_nettype none
module hse_front #(
    parameter int NUM_TERMS = hse_pkg::NUM_TERMS_DEF,
    parameter int FRAC_BITS = hse_pkg::FRAC_BITS_DEF
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  in_valid,
    output logic                                 in_ready,
    input  wire logic signed [hse_pkg::DATA_W-1:0] sample,
    input  wire logic signed [hse_pkg::DATA_W-1:0] coef_0,
    input  wire logic signed [hse_pkg::DATA_W-1:0] coef_1,
    input  wire logic signed [hse_pkg::DATA_W-1:0] mean_offset,
    input  wire logic        [hse_pkg::DATA_W-1:0] inv_scale,
    output logic                                 out_valid,
    input  wire                                  out_ready,
    output hse_pkg::hse_bus_t                    out_bus
);

    localparam int STAGES = 5;
    localparam int DW     = hse_pkg::DATA_W;
    localparam int PW     = hse_pkg::PROD_W;
    localparam logic signed [DW-1:0] ONE = DW'(1) <<< FRAC_BITS;

    logic [STAGES-1:0] v_reg;
    logic [STAGES-1:0] rdy;

    logic signed [DW-1:0]            d_reg;
    logic                            ovf1_reg;
    logic signed [PW-1:0]            prod_reg;
    logic                            ovf2_reg;
    logic signed [DW-1:0]            z_reg;
    logic                            ovf3_reg;
    logic signed [DW-1:0]            z4_reg;
    logic signed [PW-1:0]            prod1_reg;
    logic                            ovf4_reg;
    hse_pkg::hse_bus_t               bus_reg;

    logic signed [PW-1:0] diff;
    logic signed [PW-1:0] z_wide;

    always_comb
    begin
        rdy[STAGES-1] = !v_reg[STAGES-1] || out_ready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[STAGES-1];
    assign out_bus   = bus_reg;

    assign diff   = PW'(sample) - PW'(mean_offset);
    assign z_wide = hse_pkg::rescale(prod_reg, FRAC_BITS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < STAGES; k++)
            begin
                if (rdy[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            d_reg    <= hse_pkg::sat32(diff);
            ovf1_reg <= hse_pkg::is_sat(diff);
        end
        if (rdy[1])
        begin
            prod_reg <= PW'(d_reg) * $signed({1'b0, inv_scale});
            ovf2_reg <= ovf1_reg;
        end
        if (rdy[2])
        begin
            z_reg    <= hse_pkg::sat32(z_wide);
            ovf3_reg <= ovf2_reg || hse_pkg::is_sat(z_wide);
        end
        if (rdy[3])
        begin
            z4_reg    <= z_reg;
            prod1_reg <= PW'(z_reg) * PW'(coef_1);
            ovf4_reg  <= ovf3_reg;
        end
        if (rdy[4])
        begin
            bus_reg.z      <= z4_reg;
            bus_reg.h_prev <= ONE;
            bus_reg.h_curr <= z4_reg;
            // with a single term the series is coef_0 and nothing can saturate
            if (NUM_TERMS > 1)
            begin
                bus_reg.acc <= hse_pkg::ACC_W'(coef_0)
                             + hse_pkg::ACC_W'(hse_pkg::rescale(prod1_reg, FRAC_BITS));
                bus_reg.ovf <= ovf4_reg;
            end
            else
            begin
                bus_reg.acc <= hse_pkg::ACC_W'(coef_0);
                bus_reg.ovf <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

### rtl/core/hse_cell.sv
// recurrence cell: forms He_n from He_{n-1}, He_{n-2} and adds coef_n * He_n
`default_nettype none
module hse_cell #(
    parameter int ORDER     = 2,
    parameter int FRAC_BITS = hse_pkg::FRAC_BITS_DEF
) (
    input  wire                                    clk,
    input  wire                                    rst_n,
    input  wire                                    in_valid,
    output logic                                   in_ready,
    input  wire hse_pkg::hse_bus_t                 in_bus,
    input  wire logic signed [hse_pkg::DATA_W-1:0] coef,
    output logic                                   out_valid,
    input  wire                                    out_ready,
    output hse_pkg::hse_bus_t                      out_bus
);

    localparam int STAGES = 4;
    localparam int PW     = hse_pkg::PROD_W;

    logic [STAGES-1:0] v_reg;
    logic [STAGES-1:0] rdy;

    hse_pkg::hse_bus_t    b1_reg;
    logic signed [PW-1:0] prod_h_reg;
    hse_pkg::hse_bus_t    b2_reg;
    hse_pkg::hse_bus_t    b3_reg;
    logic signed [PW-1:0] prod_c_reg;
    hse_pkg::hse_bus_t    b4_reg;

    logic signed [PW-1:0] h_wide;
    hse_pkg::hse_bus_t    b2_next;
    hse_pkg::hse_bus_t    b4_next;

    always_comb
    begin
        rdy[STAGES-1] = !v_reg[STAGES-1] || out_ready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[STAGES-1];
    assign out_bus   = b4_reg;

    // He_n = z*He_{n-1} - (n-1)*He_{n-2}, subtraction exact before saturation
    assign h_wide = hse_pkg::rescale(prod_h_reg, FRAC_BITS)
                  - PW'(b1_reg.h_prev) * PW'(ORDER - 1);

    always_comb
    begin
        b2_next        = b1_reg;
        b2_next.h_prev = b1_reg.h_curr;
        b2_next.h_curr = hse_pkg::sat32(h_wide);
        b2_next.ovf    = b1_reg.ovf || hse_pkg::is_sat(h_wide);
    end

    always_comb
    begin
        b4_next     = b3_reg;
        b4_next.acc = b3_reg.acc
                    + hse_pkg::ACC_W'(hse_pkg::rescale(prod_c_reg, FRAC_BITS));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < STAGES; k++)
            begin
                if (rdy[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            b1_reg     <= in_bus;
            prod_h_reg <= PW'(in_bus.z) * PW'(in_bus.h_curr);
        end
        if (rdy[1])
        begin
            b2_reg <= b2_next;
        end
        if (rdy[2])
        begin
            b3_reg     <= b2_reg;
            prod_c_reg <= PW'(coef) * PW'(b2_reg.h_curr);
        end
        if (rdy[3])
        begin
            b4_reg <= b4_next;
        end
    end

endmodule
`default_nettype wire
